>>> hw/rtl/cv3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cv3_pkg
// Shared constants and controller/datapath interface types for the 3x3
// convolution block.
// ----------------------------------------------------------------------------
package cv3_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int POS_W      = 11;
    localparam int SIZE_W     = 12;
    localparam int PIX_W      = 31;
    localparam int CFG_W      = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int ACC_W      = 28;
    localparam int NUM_W      = 38;
    localparam int REM_W      = 32;
    localparam int Q_W        = 8;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_K_TOP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_K_MID   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_K_BOT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS    = 3'd6;

    typedef struct packed {
        logic       accept;
        logic       shift;
        logic       clear;
        logic       mac;
        logic       num;
        logic       div;
        logic       load;
        logic       last;
        logic       fdone;
        logic [1:0] slot;
        logic [1:0] tj;
        logic [1:0] ti;
    } t_cmd;

    typedef struct packed {
        logic [3:0] mask;
        logic       out_free;
    } t_sts;

endpackage

>>> hw/rtl/convolve_3x3_rgb_clamped_edges.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convolve_3x3_rgb_clamped_edges
// 3x3 RGB convolution of a raster pixel stream, replicated edges, Q8.8
// weights, divisor and bias, clamped 8-bit results.
//
//  port group   dir  word
//  s_axis       in   tdata: red, green, blue, alpha
//  m_axis       out  tdata: col, row, red, green, blue, alpha;
//                    tlast: last result of a pixel; tuser: frame done
//  i_cfg        in   register index and write data
//
// A pixel releases 0 to 4 results. Its steps are intake, window shift and five
// slot checks, then per result nine taps at one per cycle, a numerator step
// and an 8-step divide run in all three lanes.
// The output register lets the next pixel enter while the last result waits;
// a result that finds the register still full stalls until it is taken.
// Synchronous active-low reset; line buffers hold no reset.
// ----------------------------------------------------------------------------
module convolve_3x3_rgb_clamped_edges import cv3_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [31:0]          s_axis_tdata,   // red, green, blue, alpha
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [55:0]          m_axis_tdata,   // col, row, red, green, blue, alpha
    output logic                 m_axis_tlast,
    output logic                 m_axis_tuser,   // frame_done
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd               cmd;
    t_sts               sts;
    logic [SIZE_W-1:0]  w_eff;
    logic [SIZE_W-1:0]  h_eff;
    logic [CFG_W-1:0]   k_top;
    logic [CFG_W-1:0]   k_mid;
    logic [CFG_W-1:0]   k_bot;
    logic [15:0]        dabs;
    logic               dneg;
    logic signed [32:0] bd;
    logic [PIX_W-1:0]   px;

    assign px = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16],
                 s_axis_tdata[30:24]};

    cv3_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_w_eff    (w_eff),
        .o_h_eff    (h_eff),
        .o_k_top    (k_top),
        .o_k_mid    (k_mid),
        .o_k_bot    (k_bot),
        .o_dabs     (dabs),
        .o_dneg     (dneg),
        .o_bd       (bd)
    );

    cv3_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cv3_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_px        (px),
        .i_w_eff     (w_eff),
        .i_h_eff     (h_eff),
        .i_k_top     (k_top),
        .i_k_mid     (k_mid),
        .i_k_bot     (k_bot),
        .i_dabs      (dabs),
        .i_dneg      (dneg),
        .i_bd        (bd),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_fdone (m_axis_tuser)
    );

endmodule

>>> hw/rtl/cv3_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cv3_cfg
// Configuration registers and derived frame size, divisor and bias terms.
// ----------------------------------------------------------------------------
module cv3_cfg import cv3_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic [SIZE_W-1:0]    o_w_eff,
    output logic [SIZE_W-1:0]    o_h_eff,
    output logic [CFG_W-1:0]     o_k_top,
    output logic [CFG_W-1:0]     o_k_mid,
    output logic [CFG_W-1:0]     o_k_bot,
    output logic [15:0]          o_dabs,
    output logic                 o_dneg,
    output logic signed [32:0]   o_bd
);

    logic [SIZE_W-1:0]   r_width;
    logic [SIZE_W-1:0]   r_height;
    logic [CFG_W-1:0]    r_k_top;
    logic [CFG_W-1:0]    r_k_mid;
    logic [CFG_W-1:0]    r_k_bot;
    logic signed [15:0]  r_div;
    logic signed [16:0]  r_bias;
    logic signed [32:0]  r_bd;
    logic signed [15:0]  d_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIZE_W'(MAX_WIDTH);
            r_height <= SIZE_W'(MAX_HEIGHT);
            r_k_top  <= '0;
            r_k_mid  <= CFG_W'(48'd16777216);
            r_k_bot  <= '0;
            r_div    <= 16'sd256;
            r_bias   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WIDTH:   r_width  <= i_cfg_data[SIZE_W-1:0];
                REG_HEIGHT:  r_height <= i_cfg_data[SIZE_W-1:0];
                REG_K_TOP:   r_k_top  <= i_cfg_data;
                REG_K_MID:   r_k_mid  <= i_cfg_data;
                REG_K_BOT:   r_k_bot  <= i_cfg_data;
                REG_DIVISOR: r_div    <= i_cfg_data[15:0];
                REG_BIAS:    r_bias   <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    assign d_eff = (r_div == 16'sd0) ? 16'sd256 : r_div;

    always_ff @(posedge i_clk) begin
        r_bd <= r_bias * d_eff;
    end

    always_comb begin
        if (r_width == '0)                      o_w_eff = SIZE_W'(1);
        else if (r_width > SIZE_W'(MAX_WIDTH))  o_w_eff = SIZE_W'(MAX_WIDTH);
        else                                    o_w_eff = r_width;
        if (r_height == '0)                     o_h_eff = SIZE_W'(1);
        else if (r_height > SIZE_W'(MAX_HEIGHT)) o_h_eff = SIZE_W'(MAX_HEIGHT);
        else                                    o_h_eff = r_height;
    end

    assign o_dneg  = d_eff[15];
    assign o_dabs  = d_eff[15] ? 16'(-d_eff) : d_eff;
    assign o_bd    = r_bd;
    assign o_k_top = r_k_top;
    assign o_k_mid = r_k_mid;
    assign o_k_bot = r_k_bot;

endmodule

>>> hw/rtl/cv3_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cv3_ctrl
// Sequencer: pixel intake, window update, per-result tap, numerator, divide
// and output steps.
// ----------------------------------------------------------------------------
module cv3_ctrl import cv3_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_SHIFT, S_SLOT, S_MAC, S_NUM, S_DIV, S_OUT
    } t_state;

    t_state     r_state;
    logic [2:0] r_slot;
    logic [1:0] r_tj;
    logic [1:0] r_ti;
    logic [2:0] r_cnt;
    logic       slot_last;

    always_comb begin
        case (r_slot[1:0])
            2'd0:    slot_last = ~|i_sts.mask[3:1];
            2'd1:    slot_last = ~|i_sts.mask[3:2];
            2'd2:    slot_last = ~i_sts.mask[3];
            default: slot_last = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= '0;
            r_tj    <= '0;
            r_ti    <= '0;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_SHIFT;
                S_SHIFT: begin
                    r_slot  <= '0;
                    r_state <= S_SLOT;
                end
                S_SLOT: begin
                    if (r_slot[2]) begin
                        r_state <= S_IDLE;
                    end else if (i_sts.mask[r_slot[1:0]]) begin
                        r_tj    <= '0;
                        r_ti    <= '0;
                        r_state <= S_MAC;
                    end else begin
                        r_slot <= r_slot + 3'd1;
                    end
                end
                S_MAC: begin
                    if (r_ti == 2'd2) begin
                        r_ti <= '0;
                        if (r_tj == 2'd2) r_state <= S_NUM;
                        else              r_tj <= r_tj + 2'd1;
                    end else begin
                        r_ti <= r_ti + 2'd1;
                    end
                end
                S_NUM: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd7) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_sts.out_free) begin
                        r_slot  <= r_slot + 3'd1;
                        r_state <= S_SLOT;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd        = '0;
        o_cmd.slot   = r_slot[1:0];
        o_cmd.tj     = r_tj;
        o_cmd.ti     = r_ti;
        o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
        o_cmd.shift  = (r_state == S_SHIFT);
        o_cmd.clear  = (r_state == S_SLOT);
        o_cmd.mac    = (r_state == S_MAC);
        o_cmd.num    = (r_state == S_NUM);
        o_cmd.div    = (r_state == S_DIV);
        o_cmd.load   = (r_state == S_OUT) && i_sts.out_free;
        o_cmd.last   = slot_last;
        o_cmd.fdone  = (r_slot[1:0] == 2'd3);
    end

endmodule

>>> hw/rtl/cv3_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cv3_dp
// Datapath: line buffers, 3x3 window, position counters, three MAC lanes,
// 8-bit restoring divider and output register.
// ----------------------------------------------------------------------------
module cv3_dp import cv3_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [PIX_W-1:0]    i_px,
    input  logic [SIZE_W-1:0]   i_w_eff,
    input  logic [SIZE_W-1:0]   i_h_eff,
    input  logic [CFG_W-1:0]    i_k_top,
    input  logic [CFG_W-1:0]    i_k_mid,
    input  logic [CFG_W-1:0]    i_k_bot,
    input  logic [15:0]         i_dabs,
    input  logic                i_dneg,
    input  logic signed [32:0]  i_bd,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [55:0]         o_out_data,
    output logic                o_out_last,
    output logic                o_out_fdone
);

    logic [PIX_W-1:0] mem_above  [MAX_WIDTH];
    logic [PIX_W-1:0] mem_centre [MAX_WIDTH];
    logic [PIX_W-1:0] r_win [9];
    logic [PIX_W-1:0] r_above_rd;
    logic [PIX_W-1:0] r_centre_rd;
    logic [PIX_W-1:0] r_px;
    logic [POS_W-1:0] r_col_cnt;
    logic [POS_W-1:0] r_row_cnt;
    logic [POS_W-1:0] r_c;
    logic [POS_W-1:0] r_r;
    logic             r_lastcol;
    logic             r_lastrow;

    logic signed [ACC_W-1:0] r_acc [3];
    logic [REM_W-1:0]        r_rem [3];
    logic                    r_neg [3];
    logic                    r_sat [3];
    logic [Q_W-1:0]          r_q   [3];
    logic [30:0]             r_dv;
    logic [6:0]              r_alpha;

    logic             r_out_valid;
    logic [55:0]      r_out_data;
    logic             r_out_last;
    logic             r_out_fdone;

    logic [POS_W-1:0] c_eff;
    logic [POS_W-1:0] r_eff;
    logic [1:0]       top_sel;
    logic [1:0]       mid_sel;
    logic [1:0]       lc_sel;
    logic [1:0]       cc_sel;
    logic [1:0]       wrow;
    logic [1:0]       wcol;
    logic [3:0]       widx;
    logic [PIX_W-1:0] sample;
    logic [CFG_W-1:0] krow;
    logic signed [15:0] weight;
    logic [POS_W-1:0] out_x;
    logic [POS_W-1:0] out_y;
    logic [Q_W-1:0]   res [3];

    // frame position, restarted if the size shrank below it
    assign c_eff = ({1'b0, r_col_cnt} >= i_w_eff) ? '0 : r_col_cnt;
    assign r_eff = ({1'b0, r_row_cnt} >= i_h_eff) ? '0 : r_row_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_above_rd <= mem_above[c_eff];
        end
        if (i_cmd.shift) begin
            mem_above[r_c] <= r_centre_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_centre_rd <= mem_centre[c_eff];
        end
        if (i_cmd.shift) begin
            mem_centre[r_c] <= r_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_px      <= i_px;
            r_c       <= c_eff;
            r_r       <= r_eff;
            r_lastcol <= ({1'b0, c_eff} == i_w_eff - SIZE_W'(1));
            r_lastrow <= ({1'b0, r_eff} == i_h_eff - SIZE_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
            for (int k = 0; k < 9; k++) r_win[k] <= '0;
        end else if (i_cmd.shift) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k*3]   <= r_win[k*3+1];
                r_win[k*3+1] <= r_win[k*3+2];
            end
            r_win[2] <= r_above_rd;
            r_win[5] <= r_centre_rd;
            r_win[8] <= r_px;
            if (r_lastcol) begin
                r_col_cnt <= '0;
                r_row_cnt <= r_lastrow ? '0 : r_r + POS_W'(1);
            end else begin
                r_col_cnt <= r_c + POS_W'(1);
            end
        end
    end

    assign o_sts.mask[0] = (r_r != '0) && (r_c != '0);
    assign o_sts.mask[1] = (r_r != '0) && r_lastcol;
    assign o_sts.mask[2] = r_lastrow && (r_c != '0);
    assign o_sts.mask[3] = r_lastrow && r_lastcol;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // window row/column for the current tap, edge rows/columns replicated
    always_comb begin
        if (!i_cmd.slot[1]) begin
            top_sel = (r_r == POS_W'(1)) ? 2'd1 : 2'd0;
            mid_sel = 2'd1;
        end else begin
            top_sel = (r_r == '0) ? 2'd2 : 2'd1;
            mid_sel = 2'd2;
        end
        if (!i_cmd.slot[0]) begin
            lc_sel = (r_c == POS_W'(1)) ? 2'd1 : 2'd0;
            cc_sel = 2'd1;
        end else begin
            lc_sel = (r_c == '0) ? 2'd2 : 2'd1;
            cc_sel = 2'd2;
        end
        case (i_cmd.tj)
            2'd0:    wrow = top_sel;
            2'd1:    wrow = mid_sel;
            default: wrow = 2'd2;
        endcase
        case (i_cmd.ti)
            2'd0:    wcol = lc_sel;
            2'd1:    wcol = cc_sel;
            default: wcol = 2'd2;
        endcase
        case (i_cmd.tj)
            2'd0:    krow = i_k_top;
            2'd1:    krow = i_k_mid;
            default: krow = i_k_bot;
        endcase
        case (i_cmd.ti)
            2'd0:    weight = krow[15:0];
            2'd1:    weight = krow[31:16];
            default: weight = krow[47:32];
        endcase
    end

    assign widx   = {2'b00, wrow} * 4'd3 + {2'b00, wcol};
    assign sample = r_win[widx];

    always_ff @(posedge i_clk) begin
        logic [7:0]             ch;
        logic signed [24:0]     prod;
        logic signed [NUM_W-1:0] n;
        logic [REM_W-1:0]       lim;
        logic [REM_W-1:0]       dv;
        ch   = '0;
        prod = '0;
        n    = '0;
        lim  = {i_dabs, 16'b0};
        dv   = {1'b0, r_dv};
        if (i_cmd.clear) begin
            for (int k = 0; k < 3; k++) r_acc[k] <= '0;
        end
        if (i_cmd.mac) begin
            if (i_cmd.tj == 2'd1 && i_cmd.ti == 2'd1) r_alpha <= sample[6:0];
            for (int k = 0; k < 3; k++) begin
                ch   = sample[30-8*k -: 8];
                prod = $signed({1'b0, ch}) * weight;
                r_acc[k] <= r_acc[k] + ACC_W'(prod);
            end
        end
        if (i_cmd.num) begin
            r_dv <= {i_dabs, 15'b0};
            for (int k = 0; k < 3; k++) begin
                n = {{2{r_acc[k][ACC_W-1]}}, r_acc[k], 8'b0} + NUM_W'(i_bd);
                if (i_dneg) n = -n;
                r_neg[k] <= n[NUM_W-1];
                r_sat[k] <= !n[NUM_W-1] && (n[NUM_W-2:0] >= (NUM_W-1)'(lim));
                r_rem[k] <= n[REM_W-1:0];
                r_q[k]   <= '0;
            end
        end
        if (i_cmd.div) begin
            r_dv <= r_dv >> 1;
            for (int k = 0; k < 3; k++) begin
                if (r_rem[k] >= dv) begin
                    r_rem[k] <= r_rem[k] - dv;
                    r_q[k]   <= {r_q[k][6:0], 1'b1};
                end else begin
                    r_q[k]   <= {r_q[k][6:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_neg[k])      res[k] = '0;
            else if (r_sat[k]) res[k] = '1;
            else               res[k] = r_q[k];
        end
    end

    assign out_x = i_cmd.slot[0] ? r_c : r_c - POS_W'(1);
    assign out_y = i_cmd.slot[1] ? r_r : r_r - POS_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_data  <= {3'b000, r_alpha, res[2], res[1], res[0], out_y, out_x};
            r_out_last  <= i_cmd.last;
            r_out_fdone <= i_cmd.fdone;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;
    assign o_out_fdone = r_out_fdone;

endmodule

>>> hw/rtl/cv3_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cv3_checker
// Port-level checks for the convolution block, bound to the top level.
// ----------------------------------------------------------------------------
module cv3_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    // one pixel in flight at a time
    a_one_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("pixel accepted back to back");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

    a_frame_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("frame end without tlast");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind convolve_3x3_rgb_clamped_edges cv3_checker u_cv3_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
